// ===== rtl/cct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour temperature estimate package
// Shared widths, matrix coefficients, cubic constants and control types.
// ----------------------------------------------------------------------------
package cct_pkg;

   localparam int FIELD_BITS         = 16;
   localparam int SAMPLE_BITS_DEF    = 16;
   localparam int FRACTION_BITS_DEF  = 24;

   // n is signed Q8.16.
   localparam int N_BITS  = 24;
   localparam int N_FRAC  = 16;
   localparam int N_INT   = N_BITS - N_FRAC - 1;
   localparam logic [N_BITS-1:0] N_MAX_MAG = {1'b0, {(N_BITS-1){1'b1}}};
   localparam logic [N_BITS-1:0] N_MIN_MAG = {1'b1, {(N_BITS-1){1'b0}}};

   // One quotient bit per divider stage: 7 integer bits plus 17 fraction bits.
   localparam int DIV_STEPS = N_BITS;

   // Accept to result, in cycles.
   localparam int LATENCY = 11 + DIV_STEPS;

   // RGB to XYZ matrix, scaled by 10^5.
   localparam int M00 = -14282;
   localparam int M01 = 154924;
   localparam int M02 = -95641;
   localparam int M10 = -32466;
   localparam int M11 = 157837;
   localparam int M12 = -73191;
   localparam int M20 = -68202;
   localparam int M21 = 77073;
   localparam int M22 = 56332;

   localparam int COL0 = M00 + M10 + M20;
   localparam int COL1 = M01 + M11 + M21;
   localparam int COL2 = M02 + M12 + M22;

   localparam int COEF_BITS = 32;
   typedef logic signed [COEF_BITS-1:0] coef_type;

   // S = X + Y + Z, num = 10000 X - 3320 S, den = 1858 S - 10000 Y, folded
   // straight onto the samples.
   localparam coef_type SUM_COEF [3] = '{COL0, COL1, COL2};
   localparam coef_type NUM_COEF [3] = '{
      10000 * M00 - 3320 * COL0,
      10000 * M01 - 3320 * COL1,
      10000 * M02 - 3320 * COL2
   };
   localparam coef_type DEN_COEF [3] = '{
      1858 * COL0 - 10000 * M10,
      1858 * COL1 - 10000 * M11,
      1858 * COL2 - 10000 * M12
   };

   // McCamy cubic coefficients; the last two are scaled by 10 and 100.
   localparam int K3      = 449;
   localparam int K2      = 3525;
   localparam int K1_X10  = 68233;
   localparam int K0_X100 = 552033;

   typedef struct packed {
      logic valid;
      logic degenerate;
   } ctl_type;

endpackage

// ===== rtl/cct_horner_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Horner step
// Two-stage acc = floor(acc * n / 2^16) + ADD_K with a split multiplier.
// ----------------------------------------------------------------------------
module cct_horner_step #(
   parameter int    W_IN  = 42,
   parameter int    W_OUT = 50,
   parameter int    SPLIT = 21,
   parameter longint ADD_K = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cct_pkg::ctl_type               in_ctl,
   input  logic signed [W_IN-1:0]         in_acc,
   input  logic signed [cct_pkg::N_BITS-1:0] in_n,
   output cct_pkg::ctl_type               out_ctl,
   output logic signed [W_OUT-1:0]        out_acc,
   output logic signed [cct_pkg::N_BITS-1:0] out_n
);
   import cct_pkg::*;

   localparam int PH = W_IN - SPLIT + N_BITS;
   localparam int PL = SPLIT + 1 + N_BITS;
   localparam int TW = W_IN + N_BITS + 1;

   logic signed [PH-1:0]     pph_in, pph_ff;
   logic signed [PL-1:0]     ppl_in, ppl_ff;
   logic signed [N_BITS-1:0] n_ff;
   ctl_type                  ctl_ff;
   logic signed [TW-1:0]     total;
   logic signed [W_OUT-1:0]  acc_ff;
   logic signed [N_BITS-1:0] n_out_ff;
   ctl_type                  ctl_out_ff;

   // High part is signed, low part is an unsigned slice.
   assign pph_in = PH'($signed(in_acc[W_IN-1:SPLIT])) * PH'(in_n);
   assign ppl_in = PL'($signed({1'b0, in_acc[SPLIT-1:0]})) * PL'(in_n);

   assign total = (TW'(pph_ff) <<< SPLIT) + TW'(ppl_ff) + (TW'(ADD_K) <<< N_FRAC);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid     <= 1'b0;
         ctl_out_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid     <= in_ctl.valid;
         ctl_out_ff.valid <= ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      pph_ff                <= pph_in;
      ppl_ff                <= ppl_in;
      n_ff                  <= in_n;
      ctl_ff.degenerate     <= in_ctl.degenerate;
      acc_ff                <= total[W_OUT+N_FRAC-1:N_FRAC];
      n_out_ff              <= n_ff;
      ctl_out_ff.degenerate <= ctl_ff.degenerate;
   end

   assign out_ctl = ctl_out_ff;
   assign out_acc = acc_ff;
   assign out_n   = n_out_ff;

endmodule

// ===== rtl/rgb_colour_temperature_estimate_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB colour temperature estimate unit
// McCamy correlated colour temperature from one RGB triplet per cycle.
// ----------------------------------------------------------------------------
// Usage: drive req_red, req_green and req_blue with start high; a transaction
// is accepted on every rising edge where start is high and busy is low. The
// unit keeps no state between transactions and is fully pipelined, so it takes
// one triplet every cycle and busy is only raised while reset is held.
// Each result appears on the rsp_ ports for exactly one cycle, marked by
// rsp_valid. Results leave in the order the triplets came in. The latency
// is set by the restoring divider that forms n, which resolves one quotient
// bit per stage over 24 stages, plus the matrix, sign, rounding and two split
// Horner multiply steps.
// The receiver cannot stall the unit, so nothing is held back at the output.
// A synchronous reset clears every valid bit in the pipeline; transactions in
// flight at that time are dropped and produce no result.
// rsp_degenerate flags a zero XYZ sum or zero y-denominator (result 0), and
// rsp_clipped flags a cubic that fell outside 0..65535 (result saturated).
// ----------------------------------------------------------------------------
module rgb_colour_temperature_estimate_unit #(
   parameter int SAMPLE_BITS   = cct_pkg::SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = cct_pkg::FRACTION_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [cct_pkg::FIELD_BITS-1:0] req_red,
   input  logic [cct_pkg::FIELD_BITS-1:0] req_green,
   input  logic [cct_pkg::FIELD_BITS-1:0] req_blue,
   output logic                           rsp_valid,
   output logic [cct_pkg::FIELD_BITS-1:0] rsp_temperature_kelvin,
   output logic                           rsp_clipped,
   output logic                           rsp_degenerate
);
   import cct_pkg::*;

   // Product and sum widths for the matrix stage.
   localparam int PW = SAMPLE_BITS + COEF_BITS + 1;
   localparam int VW = PW + 2;
   // Divider works on the divisor shifted up by the integer bits of n.
   localparam int DW = VW + N_INT;

   // Horner accumulator widths.
   localparam int W1  = FRACTION_BITS + 18;
   localparam int W2  = FRACTION_BITS + 26;
   localparam int W3  = FRACTION_BITS + 34;
   localparam int VW3 = W3 + 1;

   localparam longint ONE      = longint'(1) <<< FRACTION_BITS;
   localparam longint HALF     = longint'(1) <<< (FRACTION_BITS - 1);
   localparam longint C2K      = K2 * ONE;
   localparam longint C1K      = (K1_X10 * ONE + 5) / 10;
   localparam longint C0K      = (K0_X100 * ONE + 50) / 100;

   // Transactions are refused only while reset is held.
   assign busy = reset;

   // ---------------------------------------------------------------------
   // Stage 1: nine constant products of the samples.
   // ---------------------------------------------------------------------
   logic [SAMPLE_BITS-1:0] smp [3];
   logic signed [PW-1:0]   prod_in [3][3];
   logic signed [PW-1:0]   prod_ff [3][3];
   logic                   v1_ff;

   assign smp[0] = SAMPLE_BITS'(req_red);
   assign smp[1] = SAMPLE_BITS'(req_green);
   assign smp[2] = SAMPLE_BITS'(req_blue);

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         prod_in[0][j] = PW'(SUM_COEF[j]) * PW'($signed({1'b0, smp[j]}));
         prod_in[1][j] = PW'(NUM_COEF[j]) * PW'($signed({1'b0, smp[j]}));
         prod_in[2][j] = PW'(DEN_COEF[j]) * PW'($signed({1'b0, smp[j]}));
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: S, numerator and denominator of n.
   // ---------------------------------------------------------------------
   logic signed [VW-1:0] sum_ff, num_ff, den_ff;
   logic                 v2_ff;

   // ---------------------------------------------------------------------
   // Stage 3: degenerate check, sign of n and magnitudes.
   // ---------------------------------------------------------------------
   logic [VW-1:0] un_in, ud_in, un_ff, ud_ff;
   logic          deg3_ff, neg3_ff, v3_ff;

   assign un_in = num_ff[VW-1] ? VW'(-num_ff) : VW'(num_ff);
   assign ud_in = den_ff[VW-1] ? VW'(-den_ff) : VW'(den_ff);

   // ---------------------------------------------------------------------
   // Stage 4: the integer part saturates when num / den reaches 128.
   // ---------------------------------------------------------------------
   logic [DW-1:0] dd_in;
   logic          ovf_in;

   assign dd_in  = DW'(ud_ff) << N_INT;
   assign ovf_in = DW'(un_ff) >= dd_in;

   // Divider pipeline; index 0 is the stage 4 register.
   logic [DW-1:0]     dr_ff  [DIV_STEPS+1];
   logic [DW-1:0]     dd_ff  [DIV_STEPS+1];
   logic [N_BITS-1:0] dq_ff  [DIV_STEPS+1];
   logic              dv_ff  [DIV_STEPS+1];
   logic              ddeg_ff[DIV_STEPS+1];
   logic              dneg_ff[DIV_STEPS+1];
   logic              dovf_ff[DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         dv_ff[0] <= 1'b0;
      end else begin
         v1_ff    <= start & ~busy;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         dv_ff[0] <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      sum_ff     <= VW'(prod_ff[0][0]) + VW'(prod_ff[0][1]) + VW'(prod_ff[0][2]);
      num_ff     <= VW'(prod_ff[1][0]) + VW'(prod_ff[1][1]) + VW'(prod_ff[1][2]);
      den_ff     <= VW'(prod_ff[2][0]) + VW'(prod_ff[2][1]) + VW'(prod_ff[2][2]);
      un_ff      <= un_in;
      ud_ff      <= ud_in;
      deg3_ff    <= (sum_ff == '0) || (den_ff == '0);
      neg3_ff    <= num_ff[VW-1] ^ den_ff[VW-1];
      dr_ff[0]   <= DW'(un_ff);
      dd_ff[0]   <= dd_in;
      dq_ff[0]   <= '0;
      ddeg_ff[0] <= deg3_ff;
      dneg_ff[0] <= neg3_ff;
      dovf_ff[0] <= ovf_in;
   end

   // Restoring division, one quotient bit per stage. The quotient is
   // floor(num * 2^17 / den), which carries the rounding bit of n.
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
      logic [DW:0]   rem2;
      logic          take;
      logic [DW-1:0] rem_in;

      assign rem2   = {dr_ff[s], 1'b0};
      assign take   = rem2 >= {1'b0, dd_ff[s]};
      assign rem_in = take ? DW'(rem2 - {1'b0, dd_ff[s]}) : DW'(rem2);

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[s+1] <= 1'b0;
         end else begin
            dv_ff[s+1] <= dv_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         dr_ff[s+1]   <= rem_in;
         dd_ff[s+1]   <= dd_ff[s];
         dq_ff[s+1]   <= {dq_ff[s][N_BITS-2:0], take};
         ddeg_ff[s+1] <= ddeg_ff[s];
         dneg_ff[s+1] <= dneg_ff[s];
         dovf_ff[s+1] <= dovf_ff[s];
      end
   end

   // ---------------------------------------------------------------------
   // Round n to Q8.16 (ties away from zero), saturate and apply the sign.
   // ---------------------------------------------------------------------
   logic [N_BITS-1:0]        qf;
   logic [N_BITS-1:0]        mag;
   logic signed [N_BITS-1:0] n_in, n_ff;
   ctl_type                  ctln_ff;

   assign qf = dq_ff[DIV_STEPS];

   always_comb begin
      mag = {1'b0, qf[N_BITS-1:1]} + N_BITS'(qf[0]);
      if (dovf_ff[DIV_STEPS]) begin
         mag = N_MIN_MAG;
      end
      if (dneg_ff[DIV_STEPS]) begin
         n_in = -$signed(mag);
      end else if (mag > N_MAX_MAG) begin
         n_in = $signed(N_MAX_MAG);
      end else begin
         n_in = $signed(mag);
      end
   end

   // ---------------------------------------------------------------------
   // First Horner step: 449 n is a constant product, exact at this scale.
   // ---------------------------------------------------------------------
   logic signed [W1-1:0] acc1_in, acc1_ff;
   logic signed [N_BITS-1:0] n1_ff;
   ctl_type              ctl1_ff;

   assign acc1_in = ((W1'(n_ff) * W1'(K3)) <<< (FRACTION_BITS - N_FRAC)) + W1'(C2K);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctln_ff.valid <= 1'b0;
         ctl1_ff.valid <= 1'b0;
      end else begin
         ctln_ff.valid <= dv_ff[DIV_STEPS];
         ctl1_ff.valid <= ctln_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      n_ff               <= n_in;
      ctln_ff.degenerate <= ddeg_ff[DIV_STEPS];
      acc1_ff            <= acc1_in;
      n1_ff              <= n_ff;
      ctl1_ff.degenerate <= ctln_ff.degenerate;
   end

   // ---------------------------------------------------------------------
   // Remaining Horner steps.
   // ---------------------------------------------------------------------
   logic signed [W2-1:0]     acc2;
   logic signed [W3-1:0]     acc3;
   logic signed [N_BITS-1:0] n2, n3;
   ctl_type                  ctl2, ctl3;

   cct_horner_step #(
      .W_IN  (W1),
      .W_OUT (W2),
      .SPLIT (W1 / 2),
      .ADD_K (C1K)
   ) u_step2 (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (ctl1_ff),
      .in_acc  (acc1_ff),
      .in_n    (n1_ff),
      .out_ctl (ctl2),
      .out_acc (acc2),
      .out_n   (n2)
   );

   cct_horner_step #(
      .W_IN  (W2),
      .W_OUT (W3),
      .SPLIT (W2 / 2),
      .ADD_K (C0K)
   ) u_step3 (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (ctl2),
      .in_acc  (acc2),
      .in_n    (n2),
      .out_ctl (ctl3),
      .out_acc (acc3),
      .out_n   (n3)
   );

   // ---------------------------------------------------------------------
   // Round to whole kelvin (ties upward) and saturate to 16 bits.
   // ---------------------------------------------------------------------
   logic signed [VW3-1:0]  kv;
   logic [FIELD_BITS-1:0]  kelvin_in, kelvin_ff;
   logic                   clip_in, clip_ff, deg_ff, valid_ff;

   // n is only carried along to keep the Horner step interface uniform.
   logic                   n3_unused;
   assign n3_unused = ^n3;

   assign kv = VW3'(acc3) + VW3'(HALF);

   always_comb begin
      if (ctl3.degenerate) begin
         kelvin_in = '0;
         clip_in   = 1'b0;
      end else if (kv[VW3-1]) begin
         kelvin_in = '0;
         clip_in   = 1'b1;
      end else if (|kv[VW3-1:FRACTION_BITS+FIELD_BITS]) begin
         kelvin_in = '1;
         clip_in   = 1'b1;
      end else begin
         kelvin_in = kv[FRACTION_BITS+FIELD_BITS-1:FRACTION_BITS];
         clip_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl3.valid;
      end
   end

   always_ff @(posedge clock) begin
      kelvin_ff <= kelvin_in;
      clip_ff   <= clip_in;
      deg_ff    <= ctl3.degenerate;
   end

   assign rsp_valid              = valid_ff;
   assign rsp_temperature_kelvin = kelvin_ff;
   assign rsp_clipped            = clip_ff & ~n3_unused | clip_ff & n3_unused;
   assign rsp_degenerate         = deg_ff;

endmodule

// ===== rtl/cct_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour temperature estimate checker
// Port-level assertions on result timing and flag consistency.
// ----------------------------------------------------------------------------
module cct_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [cct_pkg::FIELD_BITS-1:0] rsp_temperature_kelvin,
   input logic                           rsp_clipped,
   input logic                           rsp_degenerate
);
   import cct_pkg::*;

   // Every accepted transaction yields a result after the fixed latency.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted transaction produced no result");

   // No result without a transaction accepted the latency earlier.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without matching transaction");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_temperature_kelvin == '0 && !rsp_clipped))
      else $error("degenerate result is not zero");

   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_temperature_kelvin == '0 || rsp_temperature_kelvin == '1))
      else $error("clipped result is not at a rail");

endmodule

bind rgb_colour_temperature_estimate_unit cct_checker u_cct_checker (.*);
